### sv/lle_pkg.sv
// shared constants and register codes for the llg euler cell update block
package lle_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int FRAC_BITS       = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO     = 3'd0,
    REG_DAMPING  = 3'd1,
    REG_TSTEP    = 3'd2,
    REG_DEMAG_X  = 3'd3,
    REG_DEMAG_Y  = 3'd4,
    REG_DEMAG_Z  = 3'd5,
    REG_COUPLING = 3'd6
  } cfg_reg_t;

  // 1.0 in q16.16
  localparam logic [CFG_DATA_W-1:0] GYRO_RESET = 32'h0001_0000;

endpackage

### sv/lle_delay.sv
// fixed-length shift line for payload that runs beside the arithmetic
module lle_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    tap_r[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule

### sv/lle_fmul.sv
// two-stage fixed point multiplier: floor(a*b / 2^frac), saturated
module lle_fmul #(
  parameter int W = lle_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic signed [W-1:0] p_o
);
  import lle_pkg::*;

  localparam int H  = W / 2;
  localparam int PW = 2 * W;

  logic signed [W+H:0]     lo_r;
  logic signed [2*W-H-1:0] hi_r;
  logic signed [PW-1:0]    full;
  logic signed [PW-1:0]    shr;
  logic signed [W-1:0]     p_nxt;
  logic signed [W-1:0]     p_r;

  // partial products over the low and high halves of b
  always_ff @(posedge clk) begin
    lo_r <= a_i * $signed({1'b0, b_i[H-1:0]});
    hi_r <= a_i * $signed(b_i[W-1:H]);
  end

  always_comb begin
    full = (PW'(hi_r) <<< H) + PW'(lo_r);
    shr  = full >>> FRAC_BITS;
    if (shr[PW-1:W-1] == '0 || shr[PW-1:W-1] == '1) begin
      p_nxt = shr[W-1:0];
    end else if (shr[PW-1]) begin
      p_nxt = {1'b1, {(W-1){1'b0}}};
    end else begin
      p_nxt = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p_o = p_r;

endmodule

### sv/lle_cross.sv
// three-stage saturating cross product of two fixed point vectors
module lle_cross #(
  parameter int W = lle_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic signed [W-1:0] a_i [3],
  input  logic signed [W-1:0] b_i [3],
  output logic signed [W-1:0] c_o [3]
);
  import lle_pkg::*;

  logic signed [W-1:0] pos_p [3];
  logic signed [W-1:0] neg_p [3];
  logic signed [W:0]   diff  [3];
  logic signed [W-1:0] c_nxt [3];
  logic signed [W-1:0] c_r   [3];

  function automatic logic signed [W-1:0] sat1(input logic signed [W:0] x);
    logic signed [W-1:0] y;
    if (x[W] == x[W-1]) begin
      y = x[W-1:0];
    end else if (x[W]) begin
      y = {1'b1, {(W-1){1'b0}}};
    end else begin
      y = {1'b0, {(W-1){1'b1}}};
    end
    return y;
  endfunction

  for (genvar i = 0; i < 3; i++) begin : g_axis
    lle_fmul #(.W(W)) u_pos (
      .clk (clk),
      .a_i (a_i[(i+1)%3]),
      .b_i (b_i[(i+2)%3]),
      .p_o (pos_p[i])
    );
    lle_fmul #(.W(W)) u_neg (
      .clk (clk),
      .a_i (a_i[(i+2)%3]),
      .b_i (b_i[(i+1)%3]),
      .p_o (neg_p[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = (W+1)'(pos_p[i]) - (W+1)'(neg_p[i]);
      c_nxt[i] = sat1(diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c_r[i] <= c_nxt[i];
    end
  end

  assign c_o = c_r;

endmodule

### sv/llg_euler_cell_update_unit.sv
// top level: per-dot euler step of the llg equation, fully pipelined
// a request moves with its valid bit from the input register (stage 0) to the output register (stage 16)
// throughput: one request per cycle while rst_n is high, every product has its own two-stage multiplier
// reset: synchronous active-low rst_n clears the valid bits and loads register resets
// busy is high only while rst_n is low; the stages never hold, start may stay high
// the receiver cannot stall: each result stands for exactly one cycle
module llg_euler_cell_update_unit #(
  parameter int VALUE_WIDTH = lle_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration port
  input  logic                                cfg_we,
  input  logic [lle_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lle_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_m_x,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_m_y,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_m_z,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_hext_x,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_hext_y,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_hext_z,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_nsum_x,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_nsum_y,
  input  logic signed [lle_pkg::FIELD_W-1:0]  in_nsum_z,
  input  logic                                in_interior,
  // result channel
  output logic                                out_valid,
  output logic signed [lle_pkg::FIELD_W-1:0]  out_m_next_x,
  output logic signed [lle_pkg::FIELD_W-1:0]  out_m_next_y,
  output logic signed [lle_pkg::FIELD_W-1:0]  out_m_next_z
);
  import lle_pkg::*;

  localparam int W   = VALUE_WIDTH;
  // input fields and registers widened to at least the field width
  localparam int XW  = (W > FIELD_W) ? W : FIELD_W;
  // stage 0 is the input register, stage LAT-1 the output register
  localparam int LAT = 17;

  localparam logic signed [XW-1:0] FIT_HI = $signed({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [XW-1:0] FIT_LO = ~FIT_HI;

  // clamp a 32-bit field into the working width
  function automatic logic signed [W-1:0] fit(input logic signed [FIELD_W-1:0] x);
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] y;
    xe = XW'(x);
    if (xe > FIT_HI) begin
      y = FIT_HI;
    end else if (xe < FIT_LO) begin
      y = FIT_LO;
    end else begin
      y = xe;
    end
    return y[W-1:0];
  endfunction

  // saturate a sum that carries two guard bits
  function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] x);
    logic signed [W-1:0] y;
    if (x[W+1:W-1] == '0 || x[W+1:W-1] == '1) begin
      y = x[W-1:0];
    end else if (x[W+1]) begin
      y = {1'b1, {(W-1){1'b0}}};
    end else begin
      y = {1'b0, {(W-1){1'b1}}};
    end
    return y;
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] gyro_r, damp_r, tstep_r, coup_r;
  logic [CFG_DATA_W-1:0] demag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_r  <= GYRO_RESET;
      damp_r  <= '0;
      tstep_r <= '0;
      coup_r  <= '0;
      for (int k = 0; k < 3; k++) begin
        demag_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GYRO:     gyro_r     <= cfg_wdata;
        REG_DAMPING:  damp_r     <= cfg_wdata;
        REG_TSTEP:    tstep_r    <= cfg_wdata;
        REG_DEMAG_X:  demag_r[0] <= cfg_wdata;
        REG_DEMAG_Y:  demag_r[1] <= cfg_wdata;
        REG_DEMAG_Z:  demag_r[2] <= cfg_wdata;
        REG_COUPLING: coup_r     <= cfg_wdata;
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // registers clamped into the working width; the user must keep them static while requests run, unenforced
  logic signed [W-1:0] gam_w, damp_w, dt_w, coup_w;
  logic signed [W-1:0] demag_w [3];

  always_comb begin
    gam_w  = fit(gyro_r);
    damp_w = fit(damp_r);
    dt_w   = fit(tstep_r);
    coup_w = fit(coup_r);
    for (int k = 0; k < 3; k++) begin
      demag_w[k] = fit(demag_r[k]);
    end
  end

  // ---------------------------------------------------------------------
  // request handshake and valid line
  // ---------------------------------------------------------------------
  logic           accept;
  logic [LAT-1:0] v_r;
  logic [LAT-1:0] v_nxt;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;
  assign v_nxt  = {v_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: input register, fields clamped into the working width
  // ---------------------------------------------------------------------
  logic signed [W-1:0] m0_r    [3];
  logic signed [W-1:0] hext0_r [3];
  logic signed [W-1:0] nsum0_r [3];
  logic                int0_r;

  always_ff @(posedge clk) begin
    m0_r[0]    <= fit(in_m_x);
    m0_r[1]    <= fit(in_m_y);
    m0_r[2]    <= fit(in_m_z);
    hext0_r[0] <= fit(in_hext_x);
    hext0_r[1] <= fit(in_hext_y);
    hext0_r[2] <= fit(in_hext_z);
    nsum0_r[0] <= fit(in_nsum_x);
    nsum0_r[1] <= fit(in_nsum_y);
    nsum0_r[2] <= fit(in_nsum_z);
    int0_r     <= in_interior;
  end

  // ---------------------------------------------------------------------
  // stages 1-2: demag and coupling products
  // ---------------------------------------------------------------------
  logic signed [W-1:0] pdm2 [3];
  logic signed [W-1:0] pcp2 [3];

  for (genvar k = 0; k < 3; k++) begin : g_field
    lle_fmul #(.W(W)) u_demag (
      .clk (clk),
      .a_i (demag_w[k]),
      .b_i (m0_r[k]),
      .p_o (pdm2[k])
    );
    lle_fmul #(.W(W)) u_coup (
      .clk (clk),
      .a_i (coup_w),
      .b_i (nsum0_r[k]),
      .p_o (pcp2[k])
    );
  end

  // side lines for payload that waits on the products
  logic [3*W-1:0] m0_pk, m4_pk, m7_pk, m15_pk;
  logic [3*W-1:0] hext0_pk, hext2_pk;
  logic [3*W-1:0] pcp2_pk, pcp3_pk;
  logic           int3;

  assign m0_pk    = {m0_r[2], m0_r[1], m0_r[0]};
  assign hext0_pk = {hext0_r[2], hext0_r[1], hext0_r[0]};
  assign pcp2_pk  = {pcp2[2], pcp2[1], pcp2[0]};

  lle_delay #(.WIDTH(3*W), .DEPTH(4)) u_m_d4  (.clk(clk), .d_i(m0_pk),    .q_o(m4_pk));
  lle_delay #(.WIDTH(3*W), .DEPTH(3)) u_m_d7  (.clk(clk), .d_i(m4_pk),    .q_o(m7_pk));
  lle_delay #(.WIDTH(3*W), .DEPTH(8)) u_m_d15 (.clk(clk), .d_i(m7_pk),    .q_o(m15_pk));
  lle_delay #(.WIDTH(3*W), .DEPTH(2)) u_hext  (.clk(clk), .d_i(hext0_pk), .q_o(hext2_pk));
  lle_delay #(.WIDTH(3*W), .DEPTH(1)) u_pcp   (.clk(clk), .d_i(pcp2_pk),  .q_o(pcp3_pk));
  lle_delay #(.WIDTH(1),   .DEPTH(3)) u_int   (.clk(clk), .d_i(int0_r),   .q_o(int3));

  // ---------------------------------------------------------------------
  // stages 3-4: effective field, coupling only for interior dots
  // ---------------------------------------------------------------------
  logic signed [W-1:0] h1_r [3];
  logic signed [W-1:0] h_r  [3];
  logic signed [W-1:0] h1_nxt [3];
  logic signed [W-1:0] h_nxt  [3];
  logic signed [W-1:0] m4   [3];
  logic signed [W-1:0] m7   [3];
  logic signed [W-1:0] m15  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m4[k]     = m4_pk[k*W +: W];
      m7[k]     = m7_pk[k*W +: W];
      m15[k]    = m15_pk[k*W +: W];
      h1_nxt[k] = sat2((W+2)'($signed(hext2_pk[k*W +: W])) - (W+2)'(pdm2[k]));
      if (int3) begin
        h_nxt[k] = sat2((W+2)'(h1_r[k]) - (W+2)'($signed(pcp3_pk[k*W +: W])));
      end else begin
        h_nxt[k] = h1_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      h1_r[k] <= h1_nxt[k];
      h_r[k]  <= h_nxt[k];
    end
  end

  // ---------------------------------------------------------------------
  // stages 5-10: MxH, then Mx(MxH)
  // ---------------------------------------------------------------------
  logic signed [W-1:0] mxh7   [3];
  logic signed [W-1:0] mxmxh10 [3];
  logic signed [W-1:0] mxh10  [3];
  logic [3*W-1:0]      mxh7_pk, mxh10_pk;

  lle_cross #(.W(W)) u_cross_mh (.clk(clk), .a_i(m4), .b_i(h_r),  .c_o(mxh7));
  lle_cross #(.W(W)) u_cross_mm (.clk(clk), .a_i(m7), .b_i(mxh7), .c_o(mxmxh10));

  assign mxh7_pk = {mxh7[2], mxh7[1], mxh7[0]};

  lle_delay #(.WIDTH(3*W), .DEPTH(3)) u_mxh (.clk(clk), .d_i(mxh7_pk), .q_o(mxh10_pk));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mxh10[k] = mxh10_pk[k*W +: W];
    end
  end

  // ---------------------------------------------------------------------
  // stages 11-13: precession and damping terms, derivative
  // ---------------------------------------------------------------------
  logic signed [W-1:0] pgam12  [3];
  logic signed [W-1:0] pdamp12 [3];
  logic signed [W-1:0] der_r   [3];
  logic signed [W-1:0] der_nxt [3];
  logic signed [W-1:0] pdt15   [3];
  logic signed [W-1:0] next_r  [3];
  logic signed [W-1:0] next_nxt [3];

  for (genvar k = 0; k < 3; k++) begin : g_deriv
    lle_fmul #(.W(W)) u_gam (
      .clk (clk),
      .a_i (gam_w),
      .b_i (mxh10[k]),
      .p_o (pgam12[k])
    );
    lle_fmul #(.W(W)) u_damp (
      .clk (clk),
      .a_i (damp_w),
      .b_i (mxmxh10[k]),
      .p_o (pdamp12[k])
    );
    // stages 14-15: derivative times time step
    lle_fmul #(.W(W)) u_dt (
      .clk (clk),
      .a_i (der_r[k]),
      .b_i (dt_w),
      .p_o (pdt15[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // negated product may sit one past the range, guard bits hold it
      der_nxt[k]  = sat2(-(W+2)'(pgam12[k]) - (W+2)'(pdamp12[k]));
      next_nxt[k] = sat2((W+2)'(m15[k]) + (W+2)'(pdt15[k]));
    end
  end

  // stage 16 is the output register
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      der_r[k]  <= der_nxt[k];
      next_r[k] <= next_nxt[k];
    end
  end

  assign out_valid    = v_r[LAT-1];
  assign out_m_next_x = FIELD_W'(next_r[0]);
  assign out_m_next_y = FIELD_W'(next_r[1]);
  assign out_m_next_z = FIELD_W'(next_r[2]);

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // every result goes back to a request that was accepted at the head of the valid line
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // with a zero time step the dot keeps its magnetization
  a_zero_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && tstep_r == '0) |->
      (out_m_next_x == FIELD_W'($past(m15[0])) &&
       out_m_next_y == FIELD_W'($past(m15[1])) &&
       out_m_next_z == FIELD_W'($past(m15[2]))))
    else $error("magnetization and result out of step");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

### sim/llg_step_checker.sv
// checker for the llg euler cell update unit: predicts each dot update and compares results
module llg_step_checker
  import lle_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  input  logic                  busy,
  input  logic [FIELD_W-1:0]    in_m_x,
  input  logic [FIELD_W-1:0]    in_m_y,
  input  logic [FIELD_W-1:0]    in_m_z,
  input  logic [FIELD_W-1:0]    in_hext_x,
  input  logic [FIELD_W-1:0]    in_hext_y,
  input  logic [FIELD_W-1:0]    in_hext_z,
  input  logic [FIELD_W-1:0]    in_nsum_x,
  input  logic [FIELD_W-1:0]    in_nsum_y,
  input  logic [FIELD_W-1:0]    in_nsum_z,
  input  logic                  in_interior,
  input  logic                  out_valid,
  input  logic [FIELD_W-1:0]    out_m_next_x,
  input  logic [FIELD_W-1:0]    out_m_next_y,
  input  logic [FIELD_W-1:0]    out_m_next_z,
  output int                    fail_count,
  output int                    pending,
  output int                    compared
);

  // index 0 is x, 1 is y, 2 is z
  typedef logic [2:0][FIELD_W-1:0] m_next_t;

  // shadow copy of the register file
  logic [CFG_DATA_W-1:0]      gain_q;
  logic [CFG_DATA_W-1:0]      damp_q;
  logic [CFG_DATA_W-1:0]      step_q;
  logic [CFG_DATA_W-1:0]      cpl_q;
  logic [2:0][CFG_DATA_W-1:0] demag_q;

  m_next_t m_next_q[$];
  int      fails;
  int      ncmp;

  // saturate to the block's value width
  function automatic longint clamp(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (VALUE_WIDTH - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) return longint'(hi);
    if (v < lo) return longint'(lo);
    return longint'(v);
  endfunction

  // q16.16 product, floored, saturated
  function automatic longint qmul(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] p;
    wa = a;
    wb = b;
    p  = wa * wb;
    return clamp(p >>> FRAC_BITS);
  endfunction

  function automatic longint sq(input logic [31:0] v);
    return clamp(longint'($signed(v)));
  endfunction

  function automatic m_next_t predict_m_next(input logic [2:0][31:0] mag,
                                             input logic [2:0][31:0] fld,
                                             input logic [2:0][31:0] nbr,
                                             input logic inner);
    longint  m[3];
    longint  h[3];
    longint  mh[3];
    longint  mmh[3];
    longint  g;
    longint  dmp;
    longint  dt;
    longint  cpl;
    longint  dv;
    longint  nx;
    int      i;
    int      j;
    m_next_t r;
    g   = sq(gain_q);
    dmp = sq(damp_q);
    dt  = sq(step_q);
    cpl = sq(cpl_q);
    for (int k = 0; k < 3; k++) begin
      m[k] = sq(mag[k]);
      h[k] = clamp(sq(fld[k]) - qmul(sq(demag_q[k]), m[k]));
      if (inner) h[k] = clamp(h[k] - qmul(cpl, sq(nbr[k])));
    end
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      mh[k] = clamp(qmul(m[i], h[j]) - qmul(m[j], h[i]));
    end
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      mmh[k] = clamp(qmul(m[i], mh[j]) - qmul(m[j], mh[i]));
    end
    for (int k = 0; k < 3; k++) begin
      dv   = clamp(-qmul(g, mh[k]) - qmul(dmp, mmh[k]));
      nx   = clamp(m[k] + qmul(dv, dt));
      r[k] = nx[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    m_next_t want;
    m_next_t got;
    if (!rst_n) begin
      gain_q  = GYRO_RESET;
      damp_q  = '0;
      step_q  = '0;
      cpl_q   = '0;
      demag_q = '0;
      m_next_q.delete();
      fails   = 0;
      ncmp    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GYRO:     gain_q     = cfg_wdata;
          REG_DAMPING:  damp_q     = cfg_wdata;
          REG_TSTEP:    step_q     = cfg_wdata;
          REG_DEMAG_X:  demag_q[0] = cfg_wdata;
          REG_DEMAG_Y:  demag_q[1] = cfg_wdata;
          REG_DEMAG_Z:  demag_q[2] = cfg_wdata;
          REG_COUPLING: cpl_q      = cfg_wdata;
          default: ;
        endcase
      end
      // results leave before new requests enter, so a stray strobe cannot match a fresh request
      if (out_valid) begin
        got = {out_m_next_z, out_m_next_y, out_m_next_x};
        if (m_next_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result x=%h y=%h z=%h", got[0], got[1], got[2]);
        end else begin
          want = m_next_q.pop_front();
          ncmp++;
          if (want[0] !== got[0] || want[1] !== got[1] || want[2] !== got[2]) begin
            fails++;
            if (fails <= 10)
              $display("mismatch on result %0d: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                       ncmp, want[0], want[1], want[2], got[0], got[1], got[2]);
          end
        end
      end
      if (start && !busy)
        m_next_q.push_back(predict_m_next({in_m_z, in_m_y, in_m_x},
                                          {in_hext_z, in_hext_y, in_hext_x},
                                          {in_nsum_z, in_nsum_y, in_nsum_x},
                                          in_interior));
    end
    pending    <= m_next_q.size();
    fail_count <= fails;
    compared   <= ncmp;
  end

endmodule

### sim/tb_llg_euler_cell_update_unit.sv
// testbench top for the llg euler cell update unit: stimulus, register programming and verdict
module tb_llg_euler_cell_update_unit;
  import lle_pkg::*;

  // drain time after the last result, chosen to outlast the block's pipeline
  localparam int                    DRAIN_CYCLES = 21;
  localparam int                    RAND_PHASES  = 10;
  localparam int                    PHASE_DOTS   = 163;
  // index past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE    = 3'd7;
  localparam logic [31:0]           Q_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0]           Q_MIN        = 32'h8000_0000;
  localparam logic [31:0]           Q_ONE        = 32'h0001_0000;

  typedef struct packed {
    logic [2:0][31:0] m;
    logic [2:0][31:0] hext;
    logic [2:0][31:0] nsum;
    logic             interior;
  } dot_req_t;

  typedef logic [6:0][CFG_DATA_W-1:0] reg_set_t;

  typedef enum {
    SET_TYPICAL,
    SET_ALL_MAX,
    SET_ALL_MIN,
    SET_RANDOM,
    SET_MIXED
  } reg_set_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  logic signed [FIELD_W-1:0] in_m_x, in_m_y, in_m_z;
  logic signed [FIELD_W-1:0] in_hext_x, in_hext_y, in_hext_z;
  logic signed [FIELD_W-1:0] in_nsum_x, in_nsum_y, in_nsum_z;
  logic                  in_interior;
  logic                  out_valid;
  logic signed [FIELD_W-1:0] out_m_next_x, out_m_next_y, out_m_next_z;

  int fail_count;
  int pending;
  int compared;

  // stimulus bookkeeping
  int dots_sent;
  int settings_done;
  bit gaps_on;

  llg_euler_cell_update_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_m_x       (in_m_x),
    .in_m_y       (in_m_y),
    .in_m_z       (in_m_z),
    .in_hext_x    (in_hext_x),
    .in_hext_y    (in_hext_y),
    .in_hext_z    (in_hext_z),
    .in_nsum_x    (in_nsum_x),
    .in_nsum_y    (in_nsum_y),
    .in_nsum_z    (in_nsum_z),
    .in_interior  (in_interior),
    .out_valid    (out_valid),
    .out_m_next_x (out_m_next_x),
    .out_m_next_y (out_m_next_y),
    .out_m_next_z (out_m_next_z)
  );

  // watches both channels and the register port beside the block
  llg_step_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_m_x       (in_m_x),
    .in_m_y       (in_m_y),
    .in_m_z       (in_m_z),
    .in_hext_x    (in_hext_x),
    .in_hext_y    (in_hext_y),
    .in_hext_z    (in_hext_z),
    .in_nsum_x    (in_nsum_x),
    .in_nsum_y    (in_nsum_y),
    .in_nsum_z    (in_nsum_z),
    .in_interior  (in_interior),
    .out_valid    (out_valid),
    .out_m_next_x (out_m_next_x),
    .out_m_next_y (out_m_next_y),
    .out_m_next_z (out_m_next_z),
    .fail_count   (fail_count),
    .pending      (pending),
    .compared     (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or never answers
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // q16.16 value: mostly near unity so the cross products stay meaningful,
  // some full-range words for saturation and every bit, a few corner values
  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2:    v = $urandom();
      3, 4, 5, 6: v = $urandom_range(0, 262144) - 131072;
      7, 8:       v = $urandom_range(0, 4194304) - 2097152;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          3:       v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic dot_req_t rand_dot();
    dot_req_t d;
    for (int k = 0; k < 3; k++) begin
      d.m[k]    = rand_q();
      d.hext[k] = rand_q();
      d.nsum[k] = rand_q();
    end
    d.interior = 1'($urandom_range(0, 1));
    return d;
  endfunction

  function automatic dot_req_t mk_dot(input logic [31:0] mx, my, mz, hx, hy, hz,
                                      input logic [31:0] nx, ny, nz, input logic inner);
    dot_req_t d;
    d.m        = {mz, my, mx};
    d.hext     = {hz, hy, hx};
    d.nsum     = {nz, ny, nx};
    d.interior = inner;
    return d;
  endfunction

  function automatic reg_set_t make_reg_set(input reg_set_kind_t kind);
    reg_set_t s;
    case (kind)
      SET_TYPICAL: begin
        // physically sensible magnitudes: gamma and damping near unity, small dt
        s[REG_GYRO]     = $urandom_range(0, 262144) - 131072;
        s[REG_DAMPING]  = $urandom_range(0, 65536) - 32768;
        s[REG_TSTEP]    = $urandom_range(0, 8192);
        s[REG_DEMAG_X]  = $urandom_range(0, 65536);
        s[REG_DEMAG_Y]  = $urandom_range(0, 65536);
        s[REG_DEMAG_Z]  = $urandom_range(0, 65536);
        s[REG_COUPLING] = $urandom_range(0, 65536) - 32768;
      end
      SET_ALL_MAX: s = {7{Q_MAX}};
      SET_ALL_MIN: s = {7{Q_MIN}};
      SET_RANDOM: begin
        for (int k = 0; k < 7; k++) s[k] = $urandom();
      end
      default: begin
        for (int k = 0; k < 7; k++) begin
          case ($urandom_range(0, 4))
            0:       s[k] = Q_MAX;
            1:       s[k] = Q_MIN;
            2:       s[k] = '0;
            3:       s[k] = $urandom_range(0, 131072) - 65536;
            default: s[k] = $urandom();
          endcase
        end
      end
    endcase
    return s;
  endfunction

  // one request; start stays high into the next request when no gap is drawn
  task automatic issue_dot(input dot_req_t d);
    int gap;
    start       <= 1'b1;
    in_m_x      <= d.m[0];
    in_m_y      <= d.m[1];
    in_m_z      <= d.m[2];
    in_hext_x   <= d.hext[0];
    in_hext_y   <= d.hext[1];
    in_hext_z   <= d.hext[2];
    in_nsum_x   <= d.nsum[0];
    in_nsum_y   <= d.nsum[1];
    in_nsum_z   <= d.nsum[2];
    in_interior <= d.interior;
    do @(posedge clk); while (busy);
    dots_sent++;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every outstanding request has come back, then
  // lets the pipeline run empty
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes every register back to back, optionally one stray index too
  task automatic program_regs(input reg_set_t s, input bit stray);
    cfg_reg_t r;
    r = r.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= s[r];
      @(posedge clk);
      r = r.next();
    end while (r != r.first());
    if (stray) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= $urandom();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  initial begin
    reg_set_t typical;
    dots_sent     = 0;
    settings_done = 0;
    gaps_on       = 1'b1;
    // every input known from time zero
    rst_n       <= 1'b0;
    start       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_GYRO;
    cfg_wdata   <= '0;
    in_m_x      <= '0;
    in_m_y      <= '0;
    in_m_z      <= '0;
    in_hext_x   <= '0;
    in_hext_y   <= '0;
    in_hext_z   <= '0;
    in_nsum_x   <= '0;
    in_nsum_y   <= '0;
    in_nsum_z   <= '0;
    in_interior <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: dt is zero, so each dot must come back unchanged
    issue_dot(rand_dot());
    issue_dot(mk_dot(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    issue_dot(mk_dot(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
    wait_idle();

    // fixed, sensible setting for the directed dots, with a write to the
    // unused index that must leave the registers alone
    typical[REG_GYRO]     = Q_ONE;
    typical[REG_DAMPING]  = 32'h0000_4000;
    typical[REG_TSTEP]    = 32'h0000_1000;
    typical[REG_DEMAG_X]  = 32'h0000_8000;
    typical[REG_DEMAG_Y]  = 32'h0000_4000;
    typical[REG_DEMAG_Z]  = Q_ONE;
    typical[REG_COUPLING] = 32'h0000_2000;
    program_regs(typical, 1'b1);

    // zero dot, coupling on and off
    issue_dot(mk_dot('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    issue_dot(mk_dot('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    // orthogonal unit vectors: clean precession
    issue_dot(mk_dot(Q_ONE, '0, '0, '0, Q_ONE, '0, '0, '0, '0, 1'b0));
    issue_dot(mk_dot('0, '0, Q_ONE, Q_ONE, '0, '0, 32'h0004_0000, '0, '0, 1'b1));
    // every field at an extreme: saturation all the way through
    issue_dot(mk_dot(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    issue_dot(mk_dot(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
    issue_dot(mk_dot(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
    issue_dot(mk_dot(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1));
    issue_dot(mk_dot(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0));
    // one lsb negative and positive: floor rounding of tiny products
    issue_dot(mk_dot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1));
    issue_dot(mk_dot(32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                     32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    // alternating bit patterns
    issue_dot(mk_dot(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
    issue_dot(rand_dot());
    issue_dot(rand_dot());

    // random phases: each reprograms the registers while idle, cycling
    // through typical, both extremes, fully random and mixed settings;
    // sender gaps come in stretches of forty requests, on then off
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      program_regs(make_reg_set(reg_set_kind_t'(p % 5)), p[0]);
      for (int i = 0; i < PHASE_DOTS; i++) begin
        gaps_on = ((i / 40) % 2) == 0;
        issue_dot(rand_dot());
      end
    end

    wait_idle();
    $display("covered %0d dot updates under %0d register settings, %0d results compared",
             dots_sent, settings_done, compared);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
